>>> hw/rtl/bqsc_pkg.sv
// balanced quinary sum converter: shared types and constants
// used by bqsc_conv and balanced_quinary_sum_convert_unit, no dependencies
`timescale 1ns / 1ps

package bqsc_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int MAX_DIGITS_DEF  = 32;
	localparam int RESULT_CAP      = 28;

	typedef logic signed [2:0] digit_t;

	// result of the conversion unit, one digit per strobe
	typedef struct packed {
		logic   strobe;
		digit_t digit;
		logic   last;
	} bqsc_res_t;

endpackage

>>> hw/rtl/bqsc_conv.sv
// balanced quinary sum converter: total to balanced base-5 conversion and digit output
// byte-wise divide by five by reciprocal multiply, digit buffer, msd first readout
// depends on bqsc_pkg
`timescale 1ns / 1ps

module bqsc_conv import bqsc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [VALUE_WIDTH-1:0] total,
	output logic                   busy,
	output bqsc_res_t              res
);

	localparam int Depth  = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;
	localparam int IW     = $clog2(Depth);
	localparam int CW     = $clog2(Depth + 1);
	localparam int Ch     = 8;
	localparam int Chunks = (VALUE_WIDTH + Ch - 1) / Ch;
	localparam int PW     = Chunks * Ch;
	localparam int KW     = (Chunks > 1) ? $clog2(Chunks) : 1;
	// ceil(2^13 / 5), exact quotient for dividends up to 1279
	localparam logic [20:0] Recip5 = 21'd1639;

	typedef enum logic [1:0] {IDLE, DIV, DIGIT, EMIT} state_t;

	state_t                 state_q;
	logic [PW-1:0]          mag_q;
	logic [2:0]             rem_q;
	logic [KW-1:0]          ch_q;
	logic [CW-1:0]          n_q;
	logic [IW-1:0]          idx_q;
	logic                   neg_q;
	logic                   strobe_q;
	logic                   last_q;
	digit_t                 rd_q;
	digit_t                 mem [Depth];

	logic [VALUE_WIDTH-1:0] abs_total;
	logic [10:0]            part;
	logic [20:0]            prod;
	logic [Ch-1:0]          qch;
	logic [2:0]             rem_next;
	logic [PW-1:0]          mag_shift;
	logic                   carry;
	digit_t                 dig_pos;
	digit_t                 dig;
	logic [PW-1:0]          quot;
	logic [CW-1:0]          n_next;
	logic                   wr_en;
	logic                   rd_en;

	assign abs_total = total[VALUE_WIDTH-1] ?
		(~total) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : total;

	// one byte of long division by five
	always_comb begin
		part      = {rem_q, mag_q[PW-1 -: Ch]};
		prod      = 21'(part) * Recip5;
		qch       = prod[20:13];
		rem_next  = 3'(part - ({1'b0, qch, 2'b00} + {3'b000, qch}));
		mag_shift = (mag_q << Ch) | PW'(qch);
	end

	// balanced digit and carry into the quotient
	always_comb begin
		carry   = (rem_q >= 3'd3);
		dig_pos = carry ? digit_t'(rem_q + 3'd3) : digit_t'(rem_q);
		dig     = neg_q ? digit_t'(-dig_pos) : dig_pos;
		quot    = mag_q + {{(PW-1){1'b0}}, carry};
		n_next  = n_q + 1'b1;
	end

	assign wr_en = (state_q == DIGIT);
	assign rd_en = (state_q == EMIT);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[n_q[IW-1:0]] <= dig;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			mag_q    <= '0;
			rem_q    <= '0;
			ch_q     <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			neg_q    <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				IDLE: begin
					if (go) begin
						neg_q   <= total[VALUE_WIDTH-1];
						mag_q   <= PW'(abs_total);
						rem_q   <= '0;
						ch_q    <= '0;
						n_q     <= '0;
						state_q <= DIV;
					end
				end
				DIV: begin
					rem_q <= rem_next;
					mag_q <= mag_shift;
					ch_q  <= ch_q + 1'b1;
					if (ch_q == KW'(Chunks - 1)) begin
						state_q <= DIGIT;
					end
				end
				DIGIT: begin
					if ((quot != '0) && (n_next < CW'(Depth))) begin
						mag_q   <= quot;
						rem_q   <= '0;
						ch_q    <= '0;
						n_q     <= n_next;
						state_q <= DIV;
					end else begin
						idx_q   <= n_q[IW-1:0];
						state_q <= EMIT;
					end
				end
				EMIT: begin
					strobe_q <= 1'b1;
					last_q   <= (idx_q == '0);
					if (idx_q == '0) begin
						state_q <= IDLE;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != IDLE);
	assign res.strobe = strobe_q;
	assign res.digit  = rd_q;
	assign res.last   = last_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < 3'd5)
		else $error("remainder out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("digit after last digit");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> strobe_q)
		else $error("last flag without strobe");

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> state_q == IDLE)
		else $error("conversion started while busy");

endmodule

>>> hw/rtl/balanced_quinary_sum_convert_unit.sv
// balanced quinary sum converter: top level, digit accumulation and totalling
// depends on bqsc_pkg and bqsc_conv
//
// usage:
//   a transaction is accepted at a rising edge with start high and busy low. it
//   carries one balanced base-5 digit (-2..2) of a number, most significant first,
//   with number_end on the last digit of a number and list_end on the last digit
//   of the list (list_end also ends the number).
//   digits without list_end leave busy low, so a digit can be accepted every cycle.
//   on list_end, busy rises for the conversion: the FOLD state adds the last
//   number to the total, GO starts bqsc_conv, then per output digit the shared
//   divide-by-five unit takes the value one byte per cycle and forms the balanced
//   digit; then the digits are read out, following on consecutive cycles.
//   a result has 1 to min(MAX_DIGITS, 28) digits.
//   each result is held on sum_digit/final_digit for one cycle with strobe high;
//   final_digit marks the least significant digit. the receiver cannot stall.
//   reset clears the accumulator, total and sequencer; no digits are pending.
`timescale 1ns / 1ps

module balanced_quinary_sum_convert_unit import bqsc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [2:0] digit,
	input  logic              number_end,
	input  logic              list_end,
	output logic signed [2:0] sum_digit,
	output logic              final_digit,
	output logic              strobe
);

	typedef enum logic [1:0] {ACCUM, FOLD, GO} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] pend_q;
	logic                   pend_v_q;
	logic [VALUE_WIDTH-1:0] total_q;

	logic                   accept;
	logic [VALUE_WIDTH-1:0] acc_next;
	logic                   conv_go;
	logic                   conv_busy;
	bqsc_res_t              res;

	assign accept   = start && !busy;
	assign acc_next = {acc_q[VALUE_WIDTH-3:0], 2'b00} + acc_q
		+ {{(VALUE_WIDTH-3){digit[2]}}, digit};
	assign conv_go  = (state_q == GO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ACCUM;
			acc_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			total_q  <= '0;
		end else begin
			if (pend_v_q) begin
				total_q <= total_q + pend_q;
			end
			pend_v_q <= 1'b0;
			case (state_q)
				ACCUM: begin
					if (accept) begin
						if (number_end || list_end) begin
							pend_q   <= acc_next;
							pend_v_q <= 1'b1;
							acc_q    <= '0;
						end else begin
							acc_q <= acc_next;
						end
						if (list_end) begin
							state_q <= FOLD;
						end
					end
				end
				FOLD: begin
					state_q <= GO;
				end
				GO: begin
					total_q <= '0;
					state_q <= ACCUM;
				end
				default: begin
					state_q <= ACCUM;
				end
			endcase
		end
	end

	bqsc_conv #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (conv_go),
		.total  (total_q),
		.busy   (conv_busy),
		.res    (res)
	);

	assign busy        = (state_q != ACCUM) || conv_busy;
	assign strobe      = res.strobe;
	assign sum_digit   = res.digit;
	assign final_digit = res.last;

	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && list_end |=> busy)
		else $error("list end did not start conversion");

	a_fold_done: assert property (@(posedge clk) disable iff (!arst_n)
		conv_go |-> !pend_v_q)
		else $error("conversion started before last number was added");

	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_digit |-> busy)
		else $error("digit output with conversion idle");

endmodule
